// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, masked while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: label");

// Same check written as an implication from a trigger to an outcome.
`define ASSERT_IMPLY(label, clk, rst, trig, outc) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (outc)) \
      else $error("assertion failed: label");

`endif

// ===== rtl/i2cm_pkg.sv =====
// Shared types and constants of the I2C register access master.
`timescale 1ns / 1ps

package i2cm_pkg;

   // Width of the bus phase tick counter.
   localparam int DIVIDER_WIDTH = 16;

   // Widths of the fields and registers.
   localparam int ADDR_WIDTH   = 7;
   localparam int HALF_WIDTH   = 16;
   localparam int BYTE_WIDTH   = 8;
   localparam int PHASE_WIDTH  = 5;
   localparam int STAGE_WIDTH  = 2;
   localparam int COUNT_WIDTH  = 4;

   // Register indexes of the configuration port.
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEVICE_ADDRESS     = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HALF_PERIOD_CYCLES = 1'd1;

   // Reset values of the configuration registers.
   localparam logic [ADDR_WIDTH-1:0] DEVICE_ADDRESS_RESET = 7'd104;
   localparam logic [HALF_WIDTH-1:0] HALF_PERIOD_RESET    = 16'd100;

   // Bus sequencer phases.
   localparam logic [PHASE_WIDTH-1:0] PH_IDLE      = 5'd0;
   localparam logic [PHASE_WIDTH-1:0] PH_START     = 5'd1;
   localparam logic [PHASE_WIDTH-1:0] PH_BIT_LOW   = 5'd2;
   localparam logic [PHASE_WIDTH-1:0] PH_BIT_HIGH  = 5'd3;
   localparam logic [PHASE_WIDTH-1:0] PH_ACK_LOW   = 5'd4;
   localparam logic [PHASE_WIDTH-1:0] PH_ACK_HIGH  = 5'd5;
   localparam logic [PHASE_WIDTH-1:0] PH_RD_LOW    = 5'd6;
   localparam logic [PHASE_WIDTH-1:0] PH_RD_HIGH   = 5'd7;
   localparam logic [PHASE_WIDTH-1:0] PH_NACK_LOW  = 5'd8;
   localparam logic [PHASE_WIDTH-1:0] PH_NACK_HIGH = 5'd9;
   localparam logic [PHASE_WIDTH-1:0] PH_STOP_LOW  = 5'd10;
   localparam logic [PHASE_WIDTH-1:0] PH_STOP_HIGH = 5'd11;
   localparam logic [PHASE_WIDTH-1:0] PH_RS_LOW    = 5'd12;
   localparam logic [PHASE_WIDTH-1:0] PH_RS_HIGH   = 5'd13;

   // Which byte is on the bus.
   localparam logic [STAGE_WIDTH-1:0] STAGE_ADDR_W = 2'd0;
   localparam logic [STAGE_WIDTH-1:0] STAGE_INDEX  = 2'd1;
   localparam logic [STAGE_WIDTH-1:0] STAGE_DATA   = 2'd2;
   localparam logic [STAGE_WIDTH-1:0] STAGE_ADDR_R = 2'd3;

   // Number of bits in one bus byte.
   localparam logic [COUNT_WIDTH-1:0] BITS_PER_BYTE = 4'd8;

   // Padded widths of the stream payloads.
   localparam int REQ_DATA_WIDTH = 24;
   localparam int RSP_DATA_WIDTH = 16;

   // One request beat as the sequencer sees it.
   typedef struct packed {
      logic                  go;
      logic                  func;
      logic [BYTE_WIDTH-1:0] reg_index;
      logic [BYTE_WIDTH-1:0] write_data;
      logic                  sda_sample;
   } request_type;

   // One result beat.
   typedef struct packed {
      logic                  scl_level;
      logic                  sda_level;
      logic                  busy_res;
      logic                  done_res;
      logic [BYTE_WIDTH-1:0] read_data;
   } result_type;

endpackage

// ===== rtl/i2cm_seq.sv =====
// Bus sequencer of the I2C register access master: state and one-tick update.
`timescale 1ns / 1ps

module i2cm_seq
   import i2cm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  request_type           req,
   input  logic [ADDR_WIDTH-1:0] device_address,
   input  logic [HALF_WIDTH-1:0] half_period_cycles,
   output result_type            res_in
);

   localparam int LEN_WIDTH = ((DIVIDER_WIDTH + 1) > (HALF_WIDTH + 1)) ?
                              (DIVIDER_WIDTH + 1) : (HALF_WIDTH + 1);
   localparam logic [LEN_WIDTH-1:0] LEN_CAP = LEN_WIDTH'(1) << DIVIDER_WIDTH;

   logic [PHASE_WIDTH-1:0]   phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0]   bit_count_ff, bit_count_in;
   logic [BYTE_WIDTH-1:0]    shift_byte_ff, shift_byte_in;
   logic [DIVIDER_WIDTH-1:0] tick_count_ff, tick_count_in;
   logic [BYTE_WIDTH-1:0]    captured_ff, captured_in;
   logic                     op_latch_ff, op_latch_in;
   logic [BYTE_WIDTH-1:0]    index_latch_ff, index_latch_in;
   logic [BYTE_WIDTH-1:0]    data_latch_ff, data_latch_in;
   logic                     scl_ff, scl_in;
   logic                     sda_ff, sda_in;
   logic [STAGE_WIDTH-1:0]   stage_ff, stage_in;

   logic [LEN_WIDTH-1:0]     half_ext;
   logic [LEN_WIDTH-1:0]     phase_len;
   logic [LEN_WIDTH-1:0]     tick_next;
   logic                     expired;
   logic [COUNT_WIDTH-1:0]   count_inc;
   logic [BYTE_WIDTH-1:0]    shift_left;
   logic [BYTE_WIDTH-1:0]    shift_read;

   // Phase length: zero acts as one, long values clamp to the divider range.
   always_comb begin
      half_ext = LEN_WIDTH'(half_period_cycles);
      if (half_ext == '0) begin
         phase_len = LEN_WIDTH'(1);
      end else if (half_ext > LEN_CAP) begin
         phase_len = LEN_CAP;
      end else begin
         phase_len = half_ext;
      end
      tick_next = LEN_WIDTH'(tick_count_ff) + LEN_WIDTH'(1);
      expired   = (tick_next >= phase_len);
   end

   assign count_inc  = bit_count_ff + COUNT_WIDTH'(1);
   assign shift_left = {shift_byte_ff[BYTE_WIDTH-2:0], 1'b0};
   assign shift_read = {shift_byte_ff[BYTE_WIDTH-2:0], req.sda_sample};

   // Next state for one tick.
   always_comb begin
      phase_in       = phase_ff;
      bit_count_in   = bit_count_ff;
      shift_byte_in  = shift_byte_ff;
      tick_count_in  = tick_count_ff;
      captured_in    = captured_ff;
      op_latch_in    = op_latch_ff;
      index_latch_in = index_latch_ff;
      data_latch_in  = data_latch_ff;
      scl_in         = scl_ff;
      sda_in         = sda_ff;
      stage_in       = stage_ff;
      res_in.done_res = 1'b0;

      if (phase_ff == PH_IDLE) begin
         if (req.go) begin
            op_latch_in    = req.func;
            index_latch_in = req.reg_index;
            data_latch_in  = req.write_data;
            stage_in       = STAGE_ADDR_W;
            shift_byte_in  = {device_address, 1'b0};
            bit_count_in   = '0;
            phase_in       = PH_START;
            scl_in         = 1'b1;
            sda_in         = 1'b0;
            tick_count_in  = '0;
         end
      end else if (!expired) begin
         tick_count_in = tick_next[DIVIDER_WIDTH-1:0];
      end else begin
         // Every phase change restarts the tick counter.
         tick_count_in = '0;
         unique case (phase_ff)
            PH_START: begin
               bit_count_in = '0;
               phase_in     = PH_BIT_LOW;
               scl_in       = 1'b0;
               sda_in       = shift_byte_ff[BYTE_WIDTH-1];
            end
            PH_BIT_LOW: begin
               phase_in = PH_BIT_HIGH;
               scl_in   = 1'b1;
            end
            PH_BIT_HIGH: begin
               bit_count_in  = count_inc;
               shift_byte_in = shift_left;
               scl_in        = 1'b0;
               if (count_inc >= BITS_PER_BYTE) begin
                  phase_in = PH_ACK_LOW;
                  sda_in   = 1'b1;
               end else begin
                  phase_in = PH_BIT_LOW;
                  sda_in   = shift_left[BYTE_WIDTH-1];
               end
            end
            PH_ACK_LOW: begin
               phase_in = PH_ACK_HIGH;
               scl_in   = 1'b1;
               sda_in   = 1'b1;
            end
            PH_ACK_HIGH: begin
               // Hold SCL high until the slave pulls SDA low.
               if (req.sda_sample) begin
                  tick_count_in = tick_count_ff;
               end else begin
                  scl_in = 1'b0;
                  case (stage_ff)
                     STAGE_ADDR_W: begin
                        shift_byte_in = index_latch_ff;
                        stage_in      = STAGE_INDEX;
                        bit_count_in  = '0;
                        phase_in      = PH_BIT_LOW;
                        sda_in        = index_latch_ff[BYTE_WIDTH-1];
                     end
                     STAGE_INDEX: begin
                        if (op_latch_ff) begin
                           phase_in = PH_RS_LOW;
                           sda_in   = 1'b1;
                        end else begin
                           shift_byte_in = data_latch_ff;
                           stage_in      = STAGE_DATA;
                           bit_count_in  = '0;
                           phase_in      = PH_BIT_LOW;
                           sda_in        = data_latch_ff[BYTE_WIDTH-1];
                        end
                     end
                     STAGE_DATA: begin
                        phase_in = PH_STOP_LOW;
                        sda_in   = 1'b0;
                     end
                     default: begin
                        shift_byte_in = '0;
                        bit_count_in  = '0;
                        phase_in      = PH_RD_LOW;
                        sda_in        = 1'b1;
                     end
                  endcase
               end
            end
            PH_RS_LOW: begin
               phase_in = PH_RS_HIGH;
               scl_in   = 1'b1;
               sda_in   = 1'b1;
            end
            PH_RS_HIGH: begin
               stage_in      = STAGE_ADDR_R;
               shift_byte_in = {device_address, 1'b1};
               bit_count_in  = '0;
               phase_in      = PH_START;
               scl_in        = 1'b1;
               sda_in        = 1'b0;
            end
            PH_RD_LOW: begin
               phase_in = PH_RD_HIGH;
               scl_in   = 1'b1;
               sda_in   = 1'b1;
            end
            PH_RD_HIGH: begin
               // Sample the data bit on the last tick of the high half.
               shift_byte_in = shift_read;
               bit_count_in  = count_inc;
               scl_in        = 1'b0;
               sda_in        = 1'b1;
               if (count_inc >= BITS_PER_BYTE) begin
                  captured_in = shift_read;
                  phase_in    = PH_NACK_LOW;
               end else begin
                  phase_in = PH_RD_LOW;
               end
            end
            PH_NACK_LOW: begin
               phase_in = PH_NACK_HIGH;
               scl_in   = 1'b1;
               sda_in   = 1'b1;
            end
            PH_NACK_HIGH: begin
               phase_in = PH_STOP_LOW;
               scl_in   = 1'b0;
               sda_in   = 1'b0;
            end
            PH_STOP_LOW: begin
               phase_in = PH_STOP_HIGH;
               scl_in   = 1'b1;
               sda_in   = 1'b0;
            end
            PH_STOP_HIGH: begin
               phase_in        = PH_IDLE;
               scl_in          = 1'b1;
               sda_in          = 1'b1;
               res_in.done_res = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE;
               scl_in   = 1'b1;
               sda_in   = 1'b1;
            end
         endcase
      end

      res_in.scl_level = scl_in;
      res_in.sda_level = sda_in;
      res_in.busy_res  = (phase_in != PH_IDLE);
      res_in.read_data = captured_in;
   end

   // Control state is reset; latches and shifter follow the same reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bit_count_ff   <= '0;
         shift_byte_ff  <= '0;
         tick_count_ff  <= '0;
         captured_ff    <= '0;
         op_latch_ff    <= 1'b0;
         index_latch_ff <= '0;
         data_latch_ff  <= '0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         stage_ff       <= STAGE_ADDR_W;
      end else if (step) begin
         phase_ff       <= phase_in;
         bit_count_ff   <= bit_count_in;
         shift_byte_ff  <= shift_byte_in;
         tick_count_ff  <= tick_count_in;
         captured_ff    <= captured_in;
         op_latch_ff    <= op_latch_in;
         index_latch_ff <= index_latch_in;
         data_latch_ff  <= data_latch_in;
         scl_ff         <= scl_in;
         sda_ff         <= sda_in;
         stage_ff       <= stage_in;
      end
   end

endmodule

// ===== rtl/i2c_register_access_master.sv =====
// Top level of the I2C register access master: stream ports, registers, result stage.
//
//  channel  dir  handshake             payload
//  req_     in   req_tvalid/tready     one clock tick of requests and SDA sample
//  rsp_     out  rsp_tvalid/tready     bus drive levels, status and read byte
//  csr_     in   csr_wen (no wait)     device_address, half_period_cycles
//
// On each request beat the sequencer state updates in the cycle of the beat and
// the result is held in a single output register.
// One beat per cycle is sustained while rsp_tready is high; a stalled result
// stops new request beats until it is taken.
// Reset is synchronous and returns the bus to released with no result pending.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2c_register_access_master
   import i2cm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // go, reg_index[7:0], write_data[7:0], sda_sample, zero padding
   input  logic [REQ_DATA_WIDTH-1:0]  req_tdata,
   // func
   input  logic                       req_tuser,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // scl_level, sda_level, busy_res, done_res, read_data[7:0], zero padding
   output logic [RSP_DATA_WIDTH-1:0]  rsp_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic                       csr_wen,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [HALF_WIDTH-1:0]      csr_wdata
);

   logic [ADDR_WIDTH-1:0] dev_addr_ff;
   logic [HALF_WIDTH-1:0] half_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_ff;
   result_type            res_in;
   request_type           req;
   logic                  req_beat;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= DEVICE_ADDRESS_RESET;
         half_ff     <= HALF_PERIOD_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_DEVICE_ADDRESS:     dev_addr_ff <= csr_wdata[ADDR_WIDTH-1:0];
            CSR_HALF_PERIOD_CYCLES: half_ff     <= csr_wdata;
            default:                ;
         endcase
      end
   end

   // Unpack the request beat.
   assign req.go         = req_tdata[0];
   assign req.func       = req_tuser;
   assign req.reg_index  = req_tdata[8:1];
   assign req.write_data = req_tdata[16:9];
   assign req.sda_sample = req_tdata[17];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_beat   = req_tvalid && req_tready;

   i2cm_seq u_seq (
      .clock              (clock),
      .reset              (reset),
      .step               (req_beat),
      .req                (req),
      .device_address     (dev_addr_ff),
      .half_period_cycles (half_ff),
      .res_in             (res_in)
   );

   // Output register: loaded on each request beat, emptied when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_beat) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         rsp_ff <= res_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - 12){1'b0}}, rsp_ff.read_data,
                        rsp_ff.done_res, rsp_ff.busy_res,
                        rsp_ff.sda_level, rsp_ff.scl_level};

   // A request beat always leaves a result waiting in the next cycle.
   `ASSERT_IMPLY(a_beat_gives_result, clock, reset, req_beat, ##1 rsp_tvalid)
   // An idle bus is released on both lines.
   `ASSERT_IMPLY(a_idle_released, clock, reset, rsp_tvalid && !rsp_tdata[2],
                 rsp_tdata[0] && rsp_tdata[1])
   // The finishing tick reports the bus as no longer busy.
   `ASSERT_IMPLY(a_done_not_busy, clock, reset, rsp_tvalid && rsp_tdata[3],
                 !rsp_tdata[2])

endmodule
